// ===== design/smq_pkg.sv =====
// shared types and codes for the shared-buffer multi-queue core
`timescale 1ns / 1ps
`default_nettype none
package smq_pkg;

  localparam int NumQueuesDef  = 64;
  localparam int StoreBytesDef = 2048;
  localparam int IdSpace       = 64;

  localparam logic [1:0] CMD_CREATE  = 2'd0;
  localparam logic [1:0] CMD_DESTROY = 2'd1;
  localparam logic [1:0] CMD_ENQ     = 2'd2;
  localparam logic [1:0] CMD_DEQ     = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOMEM   = 2'd1;
  localparam logic [1:0] ST_ILLEGAL = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] queue_id;
    logic [7:0] data_in;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] data_out;
    logic [5:0] new_queue;
  } out_t;

  // classified request handed from front to back
  typedef struct packed {
    in_t  item;
    logic id_ok;
  } req_t;

endpackage
`default_nettype wire

// ===== design/smq_front.sv =====
// front end: request intake, queue-number check and two-entry request queue
`timescale 1ns / 1ps
`default_nettype none
module smq_front #(
  parameter int NUM_QUEUES = smq_pkg::NumQueuesDef
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire smq_pkg::in_t in_data,
  output logic              req_valid,
  input  wire logic         req_pop,
  output smq_pkg::req_t     req
);

  smq_pkg::req_t slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    cnt;
  logic          push;
  logic          pop;

  assign in_ready  = (cnt != 2'd2);
  assign req_valid = (cnt != 2'd0);
  assign req       = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = req_pop && req_valid;

  // request storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr].item  <= in_data;
      slots[wr_ptr].id_ok <= (32'(in_data.queue_id) < NUM_QUEUES);
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

// ===== design/smq_back.sv =====
// back end: queue table, linked byte store, free list and result register
`timescale 1ns / 1ps
`default_nettype none
module smq_back #(
  parameter int NUM_QUEUES  = smq_pkg::NumQueuesDef,
  parameter int STORE_BYTES = smq_pkg::StoreBytesDef
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_pop,
  input  wire smq_pkg::req_t req,
  output logic               out_valid,
  input  wire logic          out_ready,
  output smq_pkg::out_t      out_data
);

  localparam int QW    = $clog2(NUM_QUEUES);
  localparam int AW    = $clog2(STORE_BYTES);
  localparam int CW    = $clog2(STORE_BYTES + 1);
  localparam int SLOTS = (NUM_QUEUES < smq_pkg::IdSpace) ? NUM_QUEUES : smq_pkg::IdSpace;

  typedef struct packed {
    logic [AW-1:0] head;
    logic [AW-1:0] tail;
    logic [CW-1:0] cnt;
  } qent_t;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DEQ} state_t;

  state_t          state;
  smq_pkg::req_t   cur;
  qent_t           qmem [NUM_QUEUES];
  logic [7:0]      dmem [STORE_BYTES];
  logic [AW-1:0]   nmem [STORE_BYTES];
  qent_t           qe;
  logic [7:0]      drd;
  logic [AW-1:0]   nrd;
  logic [NUM_QUEUES-1:0] alloc;
  logic [CW-1:0]   total;
  logic [CW-1:0]   fresh;
  logic [CW-1:0]   recyc;
  logic [AW-1:0]   free_head;

  logic            go;
  logic [QW+5:0]   head_ext;
  logic [QW+5:0]   cur_ext;
  logic [QW-1:0]   cur_qi;
  logic [QW-1:0]   q_ra;
  logic [AW-1:0]   n_ra;
  logic            usable;
  logic            found;
  logic [QW-1:0]   slot;
  logic [QW+5:0]   slot_ext;
  logic [AW-1:0]   new_loc;

  logic            q_we;
  logic [QW-1:0]   q_wa;
  qent_t           q_wd;
  logic            d_we;
  logic            n_we;
  logic [AW-1:0]   n_wa;
  logic [AW-1:0]   n_wd;

  assign go       = req_valid && (!out_valid || out_ready);
  assign req_pop  = (state == S_IDLE) && go;
  assign head_ext = {{QW{1'b0}}, req.item.queue_id};
  assign cur_ext  = {{QW{1'b0}}, cur.item.queue_id};
  assign cur_qi   = cur_ext[QW-1:0];
  assign q_ra     = (state == S_IDLE) ? head_ext[QW-1:0] : cur_qi;
  assign n_ra     = (state == S_EXEC) ? qe.head : free_head;
  assign usable   = cur.id_ok && alloc[cur_qi];
  assign slot_ext = {6'd0, slot};
  assign new_loc  = (recyc != '0) ? free_head : fresh[AW-1:0];

  // lowest free slot within reach of the queue number
  always_comb begin
    found = 1'b0;
    slot  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!alloc[i]) begin
        found = 1'b1;
        slot  = QW'(i);
      end
    end
  end

  // memory write decode
  always_comb begin
    q_we = 1'b0;
    q_wa = cur_qi;
    q_wd = qe;
    d_we = 1'b0;
    n_we = 1'b0;
    n_wa = qe.tail;
    n_wd = new_loc;
    if (state == S_EXEC) begin
      case (cur.item.cmd)
        smq_pkg::CMD_CREATE: begin
          q_we    = found;
          q_wa    = slot;
          q_wd    = qe;
          q_wd.cnt = '0;
        end
        smq_pkg::CMD_ENQ: begin
          if (usable && total < CW'(STORE_BYTES)) begin
            q_we     = 1'b1;
            q_wd.tail = new_loc;
            q_wd.cnt  = qe.cnt + 1'b1;
            if (qe.cnt == '0) q_wd.head = new_loc;
            d_we = 1'b1;
            n_we = (qe.cnt != '0);
          end
        end
        default: ;
      endcase
    end else if (state == S_DEQ) begin
      q_we      = 1'b1;
      q_wd.head = nrd;
      q_wd.cnt  = qe.cnt - 1'b1;
      n_we      = 1'b1;
      n_wa      = qe.head;
      n_wd      = free_head;
    end
  end

  // queue table
  always_ff @(posedge clk) begin
    if (q_we) qmem[q_wa] <= q_wd;
    qe <= qmem[q_ra];
  end

  // byte store
  always_ff @(posedge clk) begin
    if (d_we) dmem[new_loc] <= cur.item.data_in;
    drd <= dmem[qe.head];
  end

  // link store
  always_ff @(posedge clk) begin
    if (n_we) nmem[n_wa] <= n_wd;
    nrd <= nmem[n_ra];
  end

  // command sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      alloc     <= '0;
      total     <= '0;
      fresh     <= '0;
      recyc     <= '0;
      free_head <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (go) begin
            cur   <= req;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          out_data.status    <= smq_pkg::ST_OK;
          out_data.data_out  <= 8'd0;
          out_data.new_queue <= 6'd0;
          out_valid          <= 1'b1;
          state              <= S_IDLE;
          case (cur.item.cmd)
            smq_pkg::CMD_CREATE: begin
              if (found) begin
                alloc[slot]        <= 1'b1;
                out_data.new_queue <= slot_ext[5:0];
              end else begin
                out_data.status <= smq_pkg::ST_NOMEM;
              end
            end
            smq_pkg::CMD_DESTROY: begin
              if (usable && qe.cnt == '0) alloc[cur_qi] <= 1'b0;
              else out_data.status <= smq_pkg::ST_ILLEGAL;
            end
            smq_pkg::CMD_ENQ: begin
              if (!usable) begin
                out_data.status <= smq_pkg::ST_ILLEGAL;
              end else if (total >= CW'(STORE_BYTES)) begin
                out_data.status <= smq_pkg::ST_NOMEM;
              end else begin
                total <= total + 1'b1;
                if (recyc != '0) begin
                  free_head <= nrd;
                  recyc     <= recyc - 1'b1;
                end else begin
                  fresh <= fresh + 1'b1;
                end
              end
            end
            default: begin
              if (!usable || qe.cnt == '0) begin
                out_data.status <= smq_pkg::ST_ILLEGAL;
              end else begin
                out_valid <= 1'b0;
                state     <= S_DEQ;
              end
            end
          endcase
        end
        S_DEQ: begin
          out_data.status    <= smq_pkg::ST_OK;
          out_data.data_out  <= drd;
          out_data.new_queue <= 6'd0;
          out_valid          <= 1'b1;
          free_head          <= qe.head;
          recyc              <= recyc + 1'b1;
          total              <= total - 1'b1;
          state              <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_total_cap: assert property (@(posedge clk) disable iff (rst)
    total <= CW'(STORE_BYTES)) else $error("byte count above store size");
  a_cells: assert property (@(posedge clk) disable iff (rst)
    total + recyc == fresh) else $error("location accounting broken");
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status != 2'd3) else $error("bad status code");
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_DEQ) |=> (state == S_IDLE && out_valid)) else $error("dequeue lost");
`endif

endmodule
`default_nettype wire

// ===== design/shared_buffer_multi_queue_core.sv =====
// top level of the shared-buffer multi-queue core
//
//  channel   direction  handshake            payload
//  in        request    in_valid / in_ready   in_data  (smq_pkg::in_t)
//  out       result     out_valid / out_ready out_data (smq_pkg::out_t)
//
// create, destroy, enqueue and a refused dequeue pass through the idle and
// execute states, a dequeue that returns a byte also through a dequeue state,
// set by the registered reads of the queue table and the byte and link stores.
// reset clears the free list, queue allocation and counters; no clearing pass.
// a two-entry request queue keeps taking requests while a result waits.
// a new command starts once the result register is free or being drained.
`timescale 1ns / 1ps
`default_nettype none
module shared_buffer_multi_queue_core #(
  parameter int NUM_QUEUES  = smq_pkg::NumQueuesDef,
  parameter int STORE_BYTES = smq_pkg::StoreBytesDef
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire smq_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output smq_pkg::out_t      out_data
);

  logic          req_valid;
  logic          req_pop;
  smq_pkg::req_t req;

  // intake
  smq_front #(.NUM_QUEUES(NUM_QUEUES)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .req_valid(req_valid), .req_pop(req_pop), .req(req)
  );

  // execution
  smq_back #(.NUM_QUEUES(NUM_QUEUES), .STORE_BYTES(STORE_BYTES)) u_back (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_pop(req_pop), .req(req),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// self-checking testbench for the shared-buffer multi-queue core
`timescale 1ns / 1ps
module tb_top;

  localparam int StoreBytes = smq_pkg::StoreBytesDef;
  localparam int SlotLimit  = (smq_pkg::NumQueuesDef < smq_pkg::IdSpace) ?
                              smq_pkg::NumQueuesDef : smq_pkg::IdSpace;
  localparam int StallLimit = 20000;

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_ready;
  smq_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  smq_pkg::out_t out_data;

  // predicted queue contents and allocation
  logic [7:0] queue_bytes [SlotLimit][$];
  logic       slot_live [SlotLimit];
  int         bytes_held;

  smq_pkg::out_t expected_results [$];
  int   mismatch_count;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   hold_cycles;
  int   quiet_cycles;

  shared_buffer_multi_queue_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // expected result of one request, updating the predicted state
  function automatic smq_pkg::out_t queue_op(input smq_pkg::in_t req);
    smq_pkg::out_t res;
    res = '0;
    res.status = smq_pkg::ST_OK;
    case (req.cmd)
      smq_pkg::CMD_CREATE: begin
        res.status = smq_pkg::ST_NOMEM;
        for (int i = 0; i < SlotLimit; i++) begin
          if (!slot_live[i]) begin
            slot_live[i] = 1'b1;
            queue_bytes[i].delete();
            res.new_queue = 6'(i);
            res.status = smq_pkg::ST_OK;
            break;
          end
        end
      end
      smq_pkg::CMD_DESTROY: begin
        if (slot_live[req.queue_id] && queue_bytes[req.queue_id].size() == 0)
          slot_live[req.queue_id] = 1'b0;
        else
          res.status = smq_pkg::ST_ILLEGAL;
      end
      smq_pkg::CMD_ENQ: begin
        if (!slot_live[req.queue_id]) res.status = smq_pkg::ST_ILLEGAL;
        else if (bytes_held >= StoreBytes) res.status = smq_pkg::ST_NOMEM;
        else begin
          queue_bytes[req.queue_id].push_back(req.data_in);
          bytes_held++;
        end
      end
      default: begin
        if (!slot_live[req.queue_id] || queue_bytes[req.queue_id].size() == 0)
          res.status = smq_pkg::ST_ILLEGAL;
        else begin
          res.data_out = queue_bytes[req.queue_id].pop_front();
          bytes_held--;
        end
      end
    endcase
    return res;
  endfunction

  // offer one request and hold it until taken, then maybe idle
  task automatic send_request(input logic [1:0] cmd, input logic [5:0] qid,
                              input logic [7:0] din);
    smq_pkg::in_t req;
    req.cmd = cmd;
    req.queue_id = qid;
    req.data_in = din;
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(queue_op(req));
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    if (in_valid) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // a live queue if any, else any number
  function automatic logic [5:0] pick_queue();
    int live [$];
    for (int i = 0; i < SlotLimit; i++) if (slot_live[i]) live.push_back(i);
    if (live.size() == 0) return 6'($urandom_range(63));
    return 6'(live[$urandom_range(live.size() - 1)]);
  endfunction

  task automatic test_basic_ops();
    send_request(smq_pkg::CMD_DEQ, 6'd0, 8'hff);
    send_request(smq_pkg::CMD_DESTROY, 6'd63, 8'h00);
    send_request(smq_pkg::CMD_ENQ, 6'd5, 8'haa);
    send_request(smq_pkg::CMD_CREATE, 6'd63, 8'hff);
    send_request(smq_pkg::CMD_CREATE, 6'd0, 8'h00);
    send_request(smq_pkg::CMD_ENQ, 6'd0, 8'h00);
    send_request(smq_pkg::CMD_ENQ, 6'd0, 8'hff);
    send_request(smq_pkg::CMD_ENQ, 6'd1, 8'h5a);
    send_request(smq_pkg::CMD_DESTROY, 6'd0, 8'h00);
    send_request(smq_pkg::CMD_DEQ, 6'd0, 8'h00);
    send_request(smq_pkg::CMD_DEQ, 6'd1, 8'h00);
    send_request(smq_pkg::CMD_DEQ, 6'd0, 8'h00);
    send_request(smq_pkg::CMD_DEQ, 6'd0, 8'h00);
    send_request(smq_pkg::CMD_DESTROY, 6'd0, 8'h00);
    send_request(smq_pkg::CMD_DESTROY, 6'd1, 8'h00);
    send_request(smq_pkg::CMD_DESTROY, 6'd1, 8'h00);
  endtask

  // every slot taken, then create refused
  task automatic test_no_free_slot();
    for (int i = 0; i <= SlotLimit; i++)
      send_request(smq_pkg::CMD_CREATE, 6'(i), 8'(i));
    send_request(smq_pkg::CMD_DESTROY, 6'd63, 8'h00);
    send_request(smq_pkg::CMD_CREATE, 6'd0, 8'h00);
    for (int i = 0; i < SlotLimit; i++)
      send_request(smq_pkg::CMD_DESTROY, 6'(i), 8'h00);
  endtask

  // receiver holds off while requests keep coming, then sender waits
  task automatic test_back_pressure();
    send_request(smq_pkg::CMD_CREATE, 6'd0, 8'h00);
    wait_drained();
    hold_cycles = 300;
    for (int i = 0; i < 40; i++) send_request(smq_pkg::CMD_ENQ, 6'd0, 8'($urandom));
    wait_drained();
    for (int i = 0; i < 41; i++) send_request(smq_pkg::CMD_DEQ, 6'd0, 8'h00);
    send_request(smq_pkg::CMD_DESTROY, 6'd0, 8'h00);
    wait_drained();
  endtask

  // mostly well-formed traffic on live queues, some noise
  task automatic test_random_traffic(input int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 10)
        send_request(smq_pkg::CMD_CREATE, 6'($urandom), 8'($urandom));
      else if (pick < 18)
        send_request(smq_pkg::CMD_DESTROY, pick_queue(), 8'($urandom));
      else if (pick < 58)
        send_request(smq_pkg::CMD_ENQ, pick_queue(), 8'($urandom));
      else if (pick < 90)
        send_request(smq_pkg::CMD_DEQ, pick_queue(), 8'($urandom));
      else send_request(2'($urandom), 6'($urandom), 8'($urandom));
    end
  endtask

  // result check and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data);
          mismatch_count++;
        end else begin
          smq_pkg::out_t exp_res;
          exp_res = expected_results.pop_front();
          if (out_data.status !== exp_res.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     exp_res.status, out_data.status);
            mismatch_count++;
          end
          if (out_data.data_out !== exp_res.data_out) begin
            $display("%0t: data_out expected %0d actual %0d", $time,
                     exp_res.data_out, out_data.data_out);
            mismatch_count++;
          end
          if (out_data.new_queue !== exp_res.new_queue) begin
            $display("%0t: new_queue expected %0d actual %0d", $time,
                     exp_res.new_queue, out_data.new_queue);
            mismatch_count++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    mismatch_count = 0;
    hold_cycles = 0;
    quiet_cycles = 0;
    bytes_held = 0;
    for (int i = 0; i < SlotLimit; i++) slot_live[i] = 1'b0;
    send_idle_pct = 15;
    recv_idle_pct = 60;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_ops();
    test_no_free_slot();
    test_random_traffic(375);
    send_idle_pct = 60;
    recv_idle_pct = 15;
    test_back_pressure();
    test_random_traffic(375);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(370);
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/smq_pkg.sv
design/smq_front.sv
design/smq_back.sv
design/shared_buffer_multi_queue_core.sv
tb/tb_top.sv
